// ===== src/b64le_pkg.sv =====
// shared types, constants and alphabet lookup for the base64 line encoder
package b64le_pkg;

    localparam int unsigned B64LE_QUEUE_DEPTH = 4;
    localparam logic [7:0] LINE_BYTES_RESET = 8'd57;
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [2:0] CHAR_IDX_FIRST = 3'd0;
    localparam logic [2:0] CHAR_IDX_THIRD = 3'd2;
    localparam logic [2:0] CHAR_IDX_FOURTH = 3'd3;
    localparam logic [2:0] CHAR_IDX_NEWLINE = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       frame_done;
    } out_word_t;

    // one closed group handed from front to back
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  fill;
        logic        newline;
        logic        last;
    } group_t;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] ch;
        case (idx) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, idx};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, idx} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, idx} - 8'd52;
            6'd62:         ch = 8'h2B;
            default:       ch = 8'h2F;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/b64le_front.sv =====
// front end: gathers bytes into groups, tracks line position, emits closed groups
module b64le_front
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       push_valid,
    input  logic       push_ready,
    output group_t     push_group
);

    logic [7:0]  line_bytes_reg;
    logic [15:0] held_reg, held_next;
    logic [1:0]  gfill_reg, gfill_next;
    logic [7:0]  lfill_reg, lfill_next;

    logic [1:0] pos;
    logic [8:0] count;
    logic       end_line;
    logic       closing;
    logic       accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos      = (gfill_reg == 2'd3) ? 2'd2 : gfill_reg;
        count    = {1'b0, lfill_reg} + 9'd1;
        end_line = in_word.frame_last || (count >= {1'b0, line_bytes_reg});
        closing  = (pos == 2'd2) || end_line;

        case (pos)
            2'd0:    push_group.bits = {in_word.in_byte, 16'h0000};
            2'd1:    push_group.bits = {held_reg[7:0], in_word.in_byte, 8'h00};
            default: push_group.bits = {held_reg, in_word.in_byte};
        endcase
        push_group.fill    = pos + 2'd1;
        push_group.newline = end_line;
        push_group.last    = in_word.frame_last;
        push_valid         = accept && closing;

        held_next  = held_reg;
        gfill_next = gfill_reg;
        lfill_next = lfill_reg;
        if (accept)
        begin
            if (closing)
            begin
                held_next  = 16'h0000;
                gfill_next = 2'd0;
                lfill_next = end_line ? 8'd0 : count[7:0];
            end
            else
            begin
                held_next  = {held_reg[7:0], in_word.in_byte};
                gfill_next = pos + 2'd1;
                lfill_next = count[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg <= LINE_BYTES_RESET;
            held_reg       <= 16'h0000;
            gfill_reg      <= 2'd0;
            lfill_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_bytes_reg <= cfg_wr_data;
            end
            held_reg  <= held_next;
            gfill_reg <= gfill_next;
            lfill_reg <= lfill_next;
        end
    end

    a_gfill_range: assert property (@(posedge clk) disable iff (!rst_n)
        gfill_reg != 2'd3)
        else $error("group fill reached three");

endmodule

// ===== src/b64le_queue.sv =====
// short fifo of closed groups between front and back
module b64le_queue
    import b64le_pkg::*;
#(
    parameter int unsigned DEPTH = B64LE_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  group_t push_group,
    output logic   pop_valid,
    input  logic   pop_ready,
    output group_t pop_group
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    group_t              mem_reg [DEPTH];
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_group  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("group pushed into full queue");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== src/b64le_back.sv =====
// back end: expands each group into characters, one per cycle unless the output stalls, into an output register
module b64le_back
    import b64le_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  group_t    pop_group,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_word_reg, out_word_next;

    logic       load;
    logic       is_final;
    logic [5:0] sextet;
    logic [7:0] ch;

    always_comb
    begin
        load     = pop_valid && (!out_valid_reg || out_ready);
        is_final = pop_group.newline ? (idx_reg == CHAR_IDX_NEWLINE)
                                     : (idx_reg == CHAR_IDX_FOURTH);
        pop_ready = load && is_final;

        case (idx_reg[1:0])
            2'd0:    sextet = pop_group.bits[23:18];
            2'd1:    sextet = pop_group.bits[17:12];
            2'd2:    sextet = pop_group.bits[11:6];
            default: sextet = pop_group.bits[5:0];
        endcase

        if (idx_reg == CHAR_IDX_NEWLINE)
        begin
            ch = NEWLINE_CHAR;
        end
        else if ((idx_reg == CHAR_IDX_THIRD && pop_group.fill < 2'd2) ||
                 (idx_reg == CHAR_IDX_FOURTH && pop_group.fill < 2'd3))
        begin
            ch = PAD_CHAR;
        end
        else
        begin
            ch = b64_char(sextet);
        end

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        if (load)
        begin
            idx_next                 = is_final ? CHAR_IDX_FIRST : idx_reg + 3'd1;
            out_valid_next           = 1'b1;
            out_word_next.out_char   = ch;
            out_word_next.run_last   = is_final;
            out_word_next.frame_done = is_final && pop_group.last;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= CHAR_IDX_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CHAR_IDX_NEWLINE)
        else $error("character index out of range");

    a_done_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.frame_done) |-> out_word.run_last)
        else $error("frame done without run last");

endmodule

// ===== src/base64_line_encoder_top.sv =====
// Base64 line encoder: takes one byte per word, returns ASCII characters one per word.
// Input channel: in_valid/in_ready with in_word (byte plus frame_last flag).
// Output channel: out_valid/out_ready with out_word (character, run_last, frame_done).
// A byte that leaves its group open gives no word; a byte that closes a group gives
// four characters, plus a newline when it ends a line or the frame.
// cfg_wr_en/cfg_wr_data set line_bytes (bytes per line); the user must write them
// only while idle, as the block itself does not enforce this. The first character
// of a closed group passes through the group queue, then the output register. The
// back end sends one character per cycle unless the output stalls. Bytes are taken
// every cycle while the group queue has room; when every byte ends a line, the
// output port sets the throughput.
// Reset clears the group, line position and queue and loads line_bytes with 57.
// When the receiver stalls, the output register holds its word, the queue fills,
// and in_ready drops once the queue is full.
module base64_line_encoder_top
    import b64le_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = B64LE_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word
);

    logic   push_valid, push_ready;
    logic   pop_valid, pop_ready;
    group_t push_group, pop_group;

    b64le_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_word     (in_word),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_group  (push_group)
    );

    b64le_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group)
    );

    b64le_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_group (pop_group),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule
